FILE: design/sfd_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sfd_pkg
// Shared codes, types and widths of the SLIP frame decoder.
// -----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned KindW = 2;

  localparam logic [ByteW-1:0] CodeFend  = 8'hC0;
  localparam logic [ByteW-1:0] CodeFesc  = 8'hDB;
  localparam logic [ByteW-1:0] CodeTfend = 8'hDC;
  localparam logic [ByteW-1:0] CodeTfesc = 8'hDD;

  localparam logic [LenW-1:0] MaxLenReset = 16'd255;

  typedef enum logic [KindW-1:0] {
    KindData     = 2'd0,
    KindDone     = 2'd1,
    KindBadEsc   = 2'd2,
    KindOverflow = 2'd3
  } kind_e;

  typedef struct packed {
    logic            in_frame;
    logic            in_escape;
    logic [LenW-1:0] count;
  } dec_state_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic [LenW-1:0]  length;
  } result_t;

  typedef struct packed {
    logic advance;
    logic load;
  } out_ctrl_t;

endpackage
`default_nettype wire

FILE: design/slip_frame_decoder_core.sv
`default_nettype none
// -----------------------------------------------------------------------------
// slip_frame_decoder_core
// SLIP frame decoder: one raw byte per word in, decoded bytes and frame events out.
// -----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, decoded combinationally by
// sfd_step, and its result word, if any, is loaded into the result register.
// Throughput: one byte per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset: outside any frame, no escape pending, count zero, limit 255.
module slip_frame_decoder_core import sfd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LenW-1:0]  cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [KindW-1:0]      result_kind_o,
  output logic [ByteW-1:0]      data_byte_o,
  output logic [LenW-1:0]       frame_length_o
);

  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic [LenW-1:0]  max_len_q;
  dec_state_t       state_q, state_d, state_nxt;
  logic             advance, fire, res_valid;
  result_t          res, out_res;
  out_ctrl_t        out_ctrl;

  assign advance    = !out_valid_o || out_ready_i;
  assign fire       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    state_d = fire ? state_nxt : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      max_len_q <= MaxLenReset;
      state_q   <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      state_q  <= state_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  sfd_step u_step (
    .byte_i      (in_byte_q),
    .max_len_i   (max_len_q),
    .state_i     (state_q),
    .state_o     (state_nxt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_ctrl = '{advance: advance, load: in_vld_q && res_valid};

  sfd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (out_ctrl),
    .res_i   (res),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign result_kind_o  = out_res.kind;
  assign data_byte_o    = out_res.data;
  assign frame_length_o = out_res.length;

endmodule
`default_nettype wire

FILE: design/sfd_step.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sfd_step
// Decodes one raw byte against the current frame state and gives the next
// state and at most one result word.
// -----------------------------------------------------------------------------
module sfd_step import sfd_pkg::*; (
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic [LenW-1:0]  max_len_i,
  input  wire dec_state_t       state_i,
  output dec_state_t            state_o,
  output logic                  res_valid_o,
  output result_t               res_o
);

  logic [ByteW-1:0] take_byte;
  logic             overflow;
  logic [LenW-1:0]  count_inc;
  logic             take;

  assign overflow  = (state_i.count >= max_len_i);
  assign count_inc = state_i.count + LenW'(1);

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '{kind: KindData, data: '0, length: state_i.count};
    take        = 1'b0;
    take_byte   = byte_i;
    if (!state_i.in_frame) begin
      if (byte_i == CodeFend) begin
        state_o = '{in_frame: 1'b1, in_escape: 1'b0, count: '0};
      end
    end else if (state_i.in_escape) begin
      state_o.in_escape = 1'b0;
      if (byte_i == CodeTfend) begin
        take      = 1'b1;
        take_byte = CodeFend;
      end else if (byte_i == CodeTfesc) begin
        take      = 1'b1;
        take_byte = CodeFesc;
      end else begin
        res_valid_o = 1'b1;
        res_o.kind  = KindBadEsc;
        state_o     = '0;
      end
    end else if (byte_i == CodeFesc) begin
      state_o.in_escape = 1'b1;
    end else if (byte_i == CodeFend) begin
      if (state_i.count != '0) begin
        res_valid_o = 1'b1;
        res_o.kind  = KindDone;
        state_o     = '0;
      end
    end else begin
      take = 1'b1;
    end

    if (take) begin
      res_valid_o = 1'b1;
      if (overflow) begin
        res_o.kind = KindOverflow;
        state_o    = '0;
      end else begin
        res_o.kind    = KindData;
        res_o.data    = take_byte;
        res_o.length  = count_inc;
        state_o.count = count_inc;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/sfd_out_stage.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sfd_out_stage
// Result register that holds one decoded word until the sink takes it.
// -----------------------------------------------------------------------------
module sfd_out_stage import sfd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire out_ctrl_t ctrl_i,
  input  wire result_t   res_i,
  output logic           valid_o,
  output result_t        res_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (ctrl_i.advance) begin
      valid_d = ctrl_i.load;
      if (ctrl_i.load) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

FILE: design/sfd_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sfd_checker
// Port-level checks of the SLIP frame decoder, bound to the top level.
// -----------------------------------------------------------------------------
module sfd_checker import sfd_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [KindW-1:0] result_kind_o,
  input wire logic [ByteW-1:0] data_byte_o,
  input wire logic [LenW-1:0]  frame_length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result word dropped while stalled.");

  a_done_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindDone |-> frame_length_o != '0)
    else $error("Completed frame reported with zero length.");

  a_data_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindData |-> frame_length_o != '0)
    else $error("Data word carries a zero running count.");

  a_abort_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KindBadEsc || result_kind_o == KindOverflow)
    |-> data_byte_o == '0)
    else $error("Abort word carries a nonzero data byte.");

endmodule

bind slip_frame_decoder_core sfd_checker u_sfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_kind_o  (result_kind_o),
  .data_byte_o    (data_byte_o),
  .frame_length_o (frame_length_o)
);
`default_nettype wire
